### sv/alsm_pkg.sv
package alsm_pkg;

   localparam int SLOTS  = 4;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int MODE_W      = 2;
   localparam int HOUR_W      = 5;
   localparam int MINUTE_W    = 6;
   localparam int SEL_W       = 2;
   localparam int SNOOZE_W    = 6;
   localparam int TIMEOUT_W   = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam int MINUTES_PER_HOUR = 60;
   localparam int HOURS_PER_DAY    = 24;
   localparam int ALARM_HOUR_BASE  = 8;
   localparam int ALARM_HOUR_STEP  = 2;
   localparam int SNOOZE_RESET     = 5;
   localparam int TIMEOUT_RESET    = 30;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK   = 2'd0,
      MODE_SNOOZE = 2'd1,
      MODE_STOP   = 2'd2,
      MODE_SET    = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SNOOZE_MINUTES = 1'd0,
      CSR_RING_TIMEOUT   = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MODIFY
   } state_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic                enable;
      logic                latch;
   } slot_entry_type;

   function automatic slot_entry_type reset_entry(input logic [SLOT_W-1:0] idx);
      slot_entry_type e;
      logic [5:0]     h;
      h = 6'(ALARM_HOUR_BASE + ALARM_HOUR_STEP * int'(idx));
      if (h >= 6'(HOURS_PER_DAY)) begin
         h = h - 6'(HOURS_PER_DAY);
      end
      e.hour   = h[HOUR_W-1:0];
      e.minute = '0;
      e.enable = 1'b0;
      e.latch  = 1'b0;
      return e;
   endfunction

endpackage

### sv/alarm_slot_matcher_with_snooze.sv
// Alarm slot matcher with snooze.
// Requests enter on the req_ channel (valid/ready); each request gives exactly
// one response on the rsp_ channel, held in an output register until taken.
// Modes: second tick, snooze slot, stop ring, set slot.
// The alarm slots live in a single-port-write synchronous RAM, one entry per
// slot, read through a registered output and written back by read-modify-write.
// A tick reads slot 0 in its accept cycle, then checks and writes back one slot
// per cycle, scanning at most SLOTS slots and fewer when a slot fires. Snooze
// and set read the slot, then modify and write it back in ST_MODIFY. Stop,
// and snooze or set to a missing slot, load their response in the accept cycle.
// One request is in flight at a time; the next is taken in the cycle after the
// response is loaded, provided the output register is empty or being drained.
// If the receiver stalls, the response waits in the output register and
// req_ready stays low until it is taken.
// The csr_ channel writes snooze minutes (index 0) and ring timeout (index 1);
// csr_ready is always high. Writes are meant for idle periods.
// Reset is synchronous: ring state clears, registers return to 5 and 30, and
// per-slot valid bits clear so each slot reads its reset time until written.
// No clearing pass is needed; the block is ready the cycle after reset.
module alarm_slot_matcher_with_snooze (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [alsm_pkg::MODE_W-1:0]       req_mode,
   input  logic [alsm_pkg::HOUR_W-1:0]       req_now_hour,
   input  logic [alsm_pkg::MINUTE_W-1:0]     req_now_minute,
   input  logic [alsm_pkg::SEL_W-1:0]        req_slot,
   input  logic [alsm_pkg::HOUR_W-1:0]       req_set_hour,
   input  logic [alsm_pkg::MINUTE_W-1:0]     req_set_minute,
   input  logic                              req_set_enable,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_fired,
   output logic [alsm_pkg::SEL_W-1:0]        rsp_fired_slot,
   output logic                              rsp_ringing,
   output logic [alsm_pkg::SEL_W-1:0]        rsp_ringing_slot,
   output logic [alsm_pkg::HOUR_W-1:0]       rsp_slot_hour,
   output logic [alsm_pkg::MINUTE_W-1:0]     rsp_slot_minute,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [alsm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [alsm_pkg::CSR_DATA_W-1:0]   csr_data
);
   import alsm_pkg::*;

   state_type             state_ff, state_in;

   mode_type              mode_ff;
   logic [HOUR_W-1:0]     now_hour_ff;
   logic [MINUTE_W-1:0]   now_minute_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [HOUR_W-1:0]     set_hour_ff;
   logic [MINUTE_W-1:0]   set_minute_ff;
   logic                  set_enable_ff;

   logic [SNOOZE_W-1:0]   snooze_ff;
   logic [TIMEOUT_W-1:0]  timeout_ff;

   logic                  ring_active_ff, ring_active_in;
   logic [SEL_W-1:0]      ring_owner_ff, ring_owner_in;
   logic [TIMEOUT_W-1:0]  ring_elapsed_ff, ring_elapsed_in;
   logic [SLOT_W-1:0]     eval_idx_ff, eval_idx_in;

   slot_entry_type        slot_mem [SLOTS];
   logic [SLOTS-1:0]      slot_valid_ff;
   slot_entry_type        rd_entry_ff;
   logic                  rd_valid_ff;
   logic [SLOT_W-1:0]     rd_addr_ff;

   logic                  mem_we;
   logic [SLOT_W-1:0]     mem_waddr;
   logic [SLOT_W-1:0]     mem_raddr;
   slot_entry_type        mem_wdata;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  fired_ff, fired_in;
   logic [SEL_W-1:0]      fired_slot_ff, fired_slot_in;
   logic                  ringing_ff, ringing_in;
   logic [SEL_W-1:0]      ringing_slot_ff, ringing_slot_in;
   logic [HOUR_W-1:0]     slot_hour_ff, slot_hour_in;
   logic [MINUTE_W-1:0]   slot_minute_ff, slot_minute_in;

   logic                  req_accept;
   logic                  csr_accept;
   logic                  req_in_range;
   mode_type              req_mode_c;
   slot_entry_type        cur_entry;
   logic                  scan_match;
   logic                  scan_fire;
   logic                  scan_last;
   logic [TIMEOUT_W-1:0]  elapsed_inc;
   logic [6:0]            snz_sum;
   logic [6:0]            snz_min;
   logic [1:0]            snz_carry;
   logic [5:0]            snz_hour;
   slot_entry_type        snoozed_entry;
   slot_entry_type        set_entry;
   slot_entry_type        scan_entry;

   logic                  load_rsp;
   logic                  res_fired;
   logic [SEL_W-1:0]      res_fired_slot;
   logic [HOUR_W-1:0]     res_hour;
   logic [MINUTE_W-1:0]   res_minute;

   assign req_accept   = req_valid && req_ready;
   assign csr_ready    = 1'b1;
   assign csr_accept   = csr_valid && csr_ready;
   assign req_mode_c   = mode_type'(req_mode);
   assign req_in_range = (int'(req_slot) < SLOTS);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fired        = fired_ff;
   assign rsp_fired_slot   = fired_slot_ff;
   assign rsp_ringing      = ringing_ff;
   assign rsp_ringing_slot = ringing_slot_ff;
   assign rsp_slot_hour    = slot_hour_ff;
   assign rsp_slot_minute  = slot_minute_ff;

   // entries never written read as their reset time
   assign cur_entry = rd_valid_ff ? rd_entry_ff : reset_entry(rd_addr_ff);

   // tick scan decision for the entry under evaluation
   always_comb begin
      scan_match = (cur_entry.hour == now_hour_ff) && (cur_entry.minute == now_minute_ff);
      scan_fire  = cur_entry.enable && scan_match && !cur_entry.latch && !ring_active_ff;
      scan_last  = (eval_idx_ff == SLOT_W'(SLOTS - 1));
      scan_entry = cur_entry;
      if (scan_fire) begin
         scan_entry.latch = 1'b1;
      end else if (!cur_entry.enable || !scan_match) begin
         scan_entry.latch = 1'b0;
      end
   end

   // snooze arithmetic: minute sum stays below three hours
   always_comb begin
      snz_sum = 7'(cur_entry.minute) + 7'(snooze_ff);
      if (snz_sum >= 7'(2 * MINUTES_PER_HOUR)) begin
         snz_min   = snz_sum - 7'(2 * MINUTES_PER_HOUR);
         snz_carry = 2'd2;
      end else if (snz_sum >= 7'(MINUTES_PER_HOUR)) begin
         snz_min   = snz_sum - 7'(MINUTES_PER_HOUR);
         snz_carry = 2'd1;
      end else begin
         snz_min   = snz_sum;
         snz_carry = 2'd0;
      end
      snz_hour = 6'(cur_entry.hour) + 6'(snz_carry);
      if (snz_hour >= 6'(HOURS_PER_DAY)) begin
         snz_hour = snz_hour - 6'(HOURS_PER_DAY);
      end
      snoozed_entry        = cur_entry;
      snoozed_entry.minute = snz_min[MINUTE_W-1:0];
      snoozed_entry.hour   = snz_hour[HOUR_W-1:0];
      snoozed_entry.latch  = 1'b0;

      set_entry        = cur_entry;
      set_entry.hour   = set_hour_ff;
      set_entry.minute = set_minute_ff;
      set_entry.enable = set_enable_ff;
   end

   assign elapsed_inc = (ring_elapsed_ff != '1) ? ring_elapsed_ff + TIMEOUT_W'(1)
                                                : ring_elapsed_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_mode_c == MODE_TICK) begin
                  state_in = ST_SCAN;
               end else if (req_mode_c != MODE_STOP && req_in_range) begin
                  state_in = ST_MODIFY;
               end
            end
         end
         ST_SCAN: begin
            if (scan_fire || scan_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_MODIFY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_ready       = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
      ring_active_in  = ring_active_ff;
      ring_owner_in   = ring_owner_ff;
      ring_elapsed_in = ring_elapsed_ff;
      eval_idx_in     = eval_idx_ff;
      mem_we          = 1'b0;
      mem_waddr       = eval_idx_ff;
      mem_wdata       = scan_entry;
      mem_raddr       = eval_idx_ff;
      load_rsp        = 1'b0;
      res_fired       = 1'b0;
      res_fired_slot  = '0;
      res_hour        = '0;
      res_minute      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_mode_c)
                  MODE_TICK: begin
                     mem_raddr   = '0;
                     eval_idx_in = '0;
                     if (ring_active_ff) begin
                        if (elapsed_inc >= timeout_ff) begin
                           ring_active_in  = 1'b0;
                           ring_elapsed_in = '0;
                        end else begin
                           ring_elapsed_in = elapsed_inc;
                        end
                     end
                  end
                  MODE_STOP: begin
                     ring_active_in  = 1'b0;
                     ring_owner_in   = '0;
                     ring_elapsed_in = '0;
                     load_rsp        = 1'b1;
                  end
                  default: begin
                     mem_raddr = SLOT_W'(req_slot);
                     if (!req_in_range) begin
                        load_rsp = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            mem_we    = 1'b1;
            mem_waddr = eval_idx_ff;
            mem_wdata = scan_entry;
            if (scan_fire) begin
               ring_active_in  = 1'b1;
               ring_owner_in   = SEL_W'(eval_idx_ff);
               ring_elapsed_in = '0;
               load_rsp        = 1'b1;
               res_fired       = 1'b1;
               res_fired_slot  = SEL_W'(eval_idx_ff);
            end else if (scan_last) begin
               load_rsp = 1'b1;
            end else begin
               eval_idx_in = eval_idx_ff + SLOT_W'(1);
               mem_raddr   = eval_idx_ff + SLOT_W'(1);
            end
         end
         ST_MODIFY: begin
            mem_we    = 1'b1;
            mem_waddr = slot_ff;
            load_rsp  = 1'b1;
            if (mode_ff == MODE_SNOOZE) begin
               mem_wdata       = snoozed_entry;
               ring_active_in  = 1'b0;
               ring_owner_in   = '0;
               ring_elapsed_in = '0;
            end else begin
               mem_wdata = set_entry;
            end
            res_hour   = mem_wdata.hour;
            res_minute = mem_wdata.minute;
         end
         default: begin
         end
      endcase

      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      fired_in        = fired_ff;
      fired_slot_in   = fired_slot_ff;
      ringing_in      = ringing_ff;
      ringing_slot_in = ringing_slot_ff;
      slot_hour_in    = slot_hour_ff;
      slot_minute_in  = slot_minute_ff;
      if (load_rsp) begin
         rsp_valid_in    = 1'b1;
         fired_in        = res_fired;
         fired_slot_in   = res_fired_slot;
         ringing_in      = ring_active_in;
         ringing_slot_in = ring_active_in ? ring_owner_in : '0;
         slot_hour_in    = res_hour;
         slot_minute_in  = res_minute;
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_entry_ff <= slot_mem[mem_raddr];
      rd_addr_ff  <= mem_raddr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (mem_we) begin
            slot_valid_ff[mem_waddr] <= 1'b1;
         end
         rd_valid_ff <= slot_valid_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ring_active_ff  <= 1'b0;
         ring_owner_ff   <= '0;
         ring_elapsed_ff <= '0;
         eval_idx_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         ring_active_ff  <= ring_active_in;
         ring_owner_ff   <= ring_owner_in;
         ring_elapsed_ff <= ring_elapsed_in;
         eval_idx_ff     <= eval_idx_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snooze_ff  <= SNOOZE_W'(SNOOZE_RESET);
         timeout_ff <= TIMEOUT_W'(TIMEOUT_RESET);
      end else if (csr_accept) begin
         case (csr_index_type'(csr_index))
            CSR_SNOOZE_MINUTES: snooze_ff  <= csr_data[SNOOZE_W-1:0];
            CSR_RING_TIMEOUT:   timeout_ff <= csr_data[TIMEOUT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff       <= req_mode_c;
         now_hour_ff   <= req_now_hour;
         now_minute_ff <= req_now_minute;
         slot_ff       <= SLOT_W'(req_slot);
         set_hour_ff   <= req_set_hour;
         set_minute_ff <= req_set_minute;
         set_enable_ff <= req_set_enable;
      end
      fired_ff        <= fired_in;
      fired_slot_ff   <= fired_slot_in;
      ringing_ff      <= ringing_in;
      ringing_slot_ff <= ringing_slot_in;
      slot_hour_ff    <= slot_hour_in;
      slot_minute_ff  <= slot_minute_in;
   end

endmodule

### test/alarm_slot_matcher_with_snooze_test.sv
`timescale 1ns / 1ps

module alarm_slot_matcher_with_snooze_test;
   import alsm_pkg::*;

   localparam int IDLE_PCT    = 17;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      mode_type              mode;
      logic [HOUR_W-1:0]     now_hour;
      logic [MINUTE_W-1:0]   now_minute;
      logic [SEL_W-1:0]      slot;
      logic [HOUR_W-1:0]     set_hour;
      logic [MINUTE_W-1:0]   set_minute;
      logic                  set_enable;
   } alarm_request_type;

   typedef struct packed {
      logic                  fired;
      logic [SEL_W-1:0]      fired_slot;
      logic                  ringing;
      logic [SEL_W-1:0]      ringing_slot;
      logic [HOUR_W-1:0]     slot_hour;
      logic [MINUTE_W-1:0]   slot_minute;
   } alarm_response_type;

   localparam int REQ_W = $bits(alarm_request_type);

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   mode_type                 req_mode = MODE_TICK;
   logic [HOUR_W-1:0]        req_now_hour = '0;
   logic [MINUTE_W-1:0]      req_now_minute = '0;
   logic [SEL_W-1:0]         req_slot = '0;
   logic [HOUR_W-1:0]        req_set_hour = '0;
   logic [MINUTE_W-1:0]      req_set_minute = '0;
   logic                     req_set_enable = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_fired;
   logic [SEL_W-1:0]         rsp_fired_slot;
   logic                     rsp_ringing;
   logic [SEL_W-1:0]         rsp_ringing_slot;
   logic [HOUR_W-1:0]        rsp_slot_hour;
   logic [MINUTE_W-1:0]      rsp_slot_minute;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   csr_index_type            csr_index = CSR_SNOOZE_MINUTES;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   // predicted block state
   logic [HOUR_W-1:0]        alarm_hr [SLOTS];
   logic [MINUTE_W-1:0]      alarm_min [SLOTS];
   logic                     armed [SLOTS];
   logic                     latched [SLOTS];
   logic                     ring_on;
   logic [SEL_W-1:0]         ring_slot;
   logic [TIMEOUT_W-1:0]     ring_secs;
   logic [SNOOZE_W-1:0]      snooze_len;
   logic [TIMEOUT_W-1:0]     ring_limit;

   // slot times as seen while queueing, used to aim ticks at alarms
   logic [HOUR_W-1:0]        aim_hour [SLOTS];
   logic [MINUTE_W-1:0]      aim_min [SLOTS];

   alarm_request_type        alarm_requests_queued [$];
   alarm_response_type       alarm_responses_due [$];
   alarm_request_type        in_flight;
   alarm_response_type       want;
   int unsigned              queued_count = 0;
   int                       requests_open = 0;
   int unsigned              mismatch_count = 0;
   int unsigned              cycle_count = 0;
   logic                     steady = 1'b0;

   alarm_slot_matcher_with_snooze i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_now_hour     (req_now_hour),
      .req_now_minute   (req_now_minute),
      .req_slot         (req_slot),
      .req_set_hour     (req_set_hour),
      .req_set_minute   (req_set_minute),
      .req_set_enable   (req_set_enable),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_fired        (rsp_fired),
      .rsp_fired_slot   (rsp_fired_slot),
      .rsp_ringing      (rsp_ringing),
      .rsp_ringing_slot (rsp_ringing_slot),
      .rsp_slot_hour    (rsp_slot_hour),
      .rsp_slot_minute  (rsp_slot_minute),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #6 clock = ~clock;

   function automatic void reset_alarms();
      for (int i = 0; i < SLOTS; i++) begin
         alarm_hr[i]  = HOUR_W'((ALARM_HOUR_BASE + ALARM_HOUR_STEP * i) % HOURS_PER_DAY);
         alarm_min[i] = '0;
         armed[i]     = 1'b0;
         latched[i]   = 1'b0;
         aim_hour[i]  = alarm_hr[i];
         aim_min[i]   = '0;
      end
      ring_on    = 1'b0;
      ring_slot  = '0;
      ring_secs  = '0;
      snooze_len = SNOOZE_W'(SNOOZE_RESET);
      ring_limit = TIMEOUT_W'(TIMEOUT_RESET);
   endfunction

   function automatic alarm_response_type alarm_step(alarm_request_type rq);
      alarm_response_type res;
      int                 sum;
      logic               done;
      res  = '0;
      done = 1'b0;
      case (rq.mode)
         MODE_TICK: begin
            if (ring_on) begin
               if (ring_secs != '1) begin
                  ring_secs = ring_secs + TIMEOUT_W'(1);
               end
               if (ring_secs >= ring_limit) begin
                  ring_on   = 1'b0;
                  ring_secs = '0;
               end
            end
            for (int i = 0; i < SLOTS; i++) begin
               if (!done) begin
                  if (!armed[i]) begin
                     latched[i] = 1'b0;
                  end else if (alarm_hr[i] == rq.now_hour && alarm_min[i] == rq.now_minute) begin
                     if (!latched[i] && !ring_on) begin
                        latched[i]     = 1'b1;
                        ring_on        = 1'b1;
                        ring_slot      = SEL_W'(i);
                        ring_secs      = '0;
                        res.fired      = 1'b1;
                        res.fired_slot = SEL_W'(i);
                        done           = 1'b1;
                     end
                  end else begin
                     latched[i] = 1'b0;
                  end
               end
            end
         end
         MODE_STOP: begin
            ring_on   = 1'b0;
            ring_slot = '0;
            ring_secs = '0;
         end
         MODE_SNOOZE: begin
            sum = int'(alarm_min[rq.slot]) + int'(snooze_len);
            ring_on   = 1'b0;
            ring_slot = '0;
            ring_secs = '0;
            alarm_min[rq.slot] = MINUTE_W'(sum % MINUTES_PER_HOUR);
            alarm_hr[rq.slot]  = HOUR_W'((int'(alarm_hr[rq.slot]) + sum / MINUTES_PER_HOUR)
                                         % HOURS_PER_DAY);
            latched[rq.slot]   = 1'b0;
            res.slot_hour      = alarm_hr[rq.slot];
            res.slot_minute    = alarm_min[rq.slot];
         end
         default: begin
            alarm_hr[rq.slot]  = rq.set_hour;
            alarm_min[rq.slot] = rq.set_minute;
            armed[rq.slot]     = rq.set_enable;
            res.slot_hour      = alarm_hr[rq.slot];
            res.slot_minute    = alarm_min[rq.slot];
         end
      endcase
      res.ringing      = ring_on;
      res.ringing_slot = ring_on ? ring_slot : '0;
      return res;
   endfunction

   function automatic void push_req(alarm_request_type rq);
      alarm_requests_queued.push_back(rq);
      queued_count++;
      requests_open++;
   endfunction

   function automatic void push_tick(logic [HOUR_W-1:0] h, logic [MINUTE_W-1:0] m);
      alarm_request_type rq;
      rq            = REQ_W'($urandom);
      rq.mode       = MODE_TICK;
      rq.now_hour   = h;
      rq.now_minute = m;
      push_req(rq);
   endfunction

   function automatic void push_set(logic [SEL_W-1:0] s, logic [HOUR_W-1:0] h,
                                    logic [MINUTE_W-1:0] m, logic e);
      alarm_request_type rq;
      rq            = REQ_W'($urandom);
      rq.mode       = MODE_SET;
      rq.slot       = s;
      rq.set_hour   = h;
      rq.set_minute = m;
      rq.set_enable = e;
      aim_hour[s]   = h;
      aim_min[s]    = m;
      push_req(rq);
   endfunction

   function automatic void push_snooze(logic [SEL_W-1:0] s);
      alarm_request_type rq;
      int                sum;
      rq          = REQ_W'($urandom);
      rq.mode     = MODE_SNOOZE;
      rq.slot     = s;
      sum         = int'(aim_min[s]) + int'(snooze_len);
      aim_min[s]  = MINUTE_W'(sum % MINUTES_PER_HOUR);
      aim_hour[s] = HOUR_W'((int'(aim_hour[s]) + sum / MINUTES_PER_HOUR) % HOURS_PER_DAY);
      push_req(rq);
   endfunction

   function automatic void push_stop();
      alarm_request_type rq;
      rq      = REQ_W'($urandom);
      rq.mode = MODE_STOP;
      push_req(rq);
   endfunction

   function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
         end
      end
   endfunction

   task automatic wait_idle();
      do @(posedge clock); while (requests_open != 0);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SNOOZE_MINUTES) begin
         snooze_len = data[SNOOZE_W-1:0];
      end else begin
         ring_limit = data[TIMEOUT_W-1:0];
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(int unsigned n);
      int unsigned target;
      int unsigned r;
      int unsigned k;
      logic [SEL_W-1:0] s;
      target = queued_count + n;
      while (queued_count < target) begin
         r = $urandom_range(99);
         s = SEL_W'($urandom_range(SLOTS - 1));
         if (r < 45) begin
            // often arm a slot, tick on its time a few times, then sometimes snooze or stop the ring
            if ($urandom_range(3) != 0) begin
               push_set(s, HOUR_W'($urandom_range(23)), MINUTE_W'($urandom_range(59)),
                        $urandom_range(4) != 0);
            end
            if ($urandom_range(3) == 0) begin
               push_set(SEL_W'($urandom_range(SLOTS - 1)), aim_hour[s], aim_min[s], 1'b1);
            end
            k = $urandom_range(7, 2);
            repeat (k) push_tick(aim_hour[s], aim_min[s]);
            case ($urandom_range(3))
               0: begin
                  push_snooze(s);
                  k = $urandom_range(2);
                  repeat (k) push_tick(aim_hour[s], aim_min[s]);
               end
               1: push_stop();
               default: ;
            endcase
         end else if (r < 70) begin
            push_tick(aim_hour[s], aim_min[s]);
         end else if (r < 80) begin
            push_tick(HOUR_W'($urandom_range(31)), MINUTE_W'($urandom_range(63)));
         end else if (r < 88) begin
            push_set(s, HOUR_W'($urandom_range(31)), MINUTE_W'($urandom_range(63)),
                     1'($urandom_range(1)));
         end else if (r < 94) begin
            push_snooze(s);
         end else begin
            push_stop();
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            alarm_responses_due.push_back(alarm_step(in_flight));
         end
         if (!req_valid || req_ready) begin
            if (alarm_requests_queued.size() != 0 &&
                (steady || $urandom_range(99) >= IDLE_PCT)) begin
               in_flight = alarm_requests_queued.pop_front();
               req_valid      <= 1'b1;
               req_mode       <= in_flight.mode;
               req_now_hour   <= in_flight.now_hour;
               req_now_minute <= in_flight.now_minute;
               req_slot       <= in_flight.slot;
               req_set_hour   <= in_flight.set_hour;
               req_set_minute <= in_flight.set_minute;
               req_set_enable <= in_flight.set_enable;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (alarm_responses_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: response with none outstanding", $time);
            end
         end else begin
            want = alarm_responses_due.pop_front();
            requests_open--;
            check_field("fired", want.fired, rsp_fired);
            check_field("fired_slot", want.fired_slot, rsp_fired_slot);
            check_field("ringing", want.ringing, rsp_ringing);
            check_field("ringing_slot", want.ringing_slot, rsp_ringing_slot);
            check_field("slot_hour", want.slot_hour, rsp_slot_hour);
            check_field("slot_minute", want.slot_minute, rsp_slot_minute);
         end
      end
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("alarm_slot_matcher_with_snooze_test failed");
         $finish;
      end
   end

   initial begin
      reset_alarms();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // disabled slots, priority, latch, ring blocking, wrap on snooze
      push_tick(8, 0);
      push_set(0, 8, 0, 1'b1);
      push_set(1, 8, 0, 1'b1);
      push_tick(8, 0);
      push_tick(8, 0);
      push_stop();
      push_tick(8, 0);
      push_snooze(1);
      push_set(3, 31, 63, 1'b1);
      push_snooze(3);
      push_set(2, 23, 59, 1'b1);
      push_snooze(2);
      push_tick(31, 63);
      push_tick(0, 4);
      push_set(2, 0, 0, 1'b0);
      push_stop();
      wait_idle();

      write_csr(CSR_SNOOZE_MINUTES, 59);
      write_csr(CSR_RING_TIMEOUT, 1);
      push_set(0, 21, 63, 1'b1);
      push_snooze(0);
      push_tick(23, 2);
      push_tick(23, 2);
      push_tick(23, 3);
      run_random(200);
      wait_idle();

      // timeout of zero ends a ring on the next tick
      write_csr(CSR_SNOOZE_MINUTES, 1);
      write_csr(CSR_RING_TIMEOUT, 0);
      push_stop();
      push_set(1, 3, 0, 1'b1);
      push_tick(3, 0);
      push_tick(3, 0);
      run_random(150);
      wait_idle();

      // longest ring, elapsed count runs up to its limit
      write_csr(CSR_SNOOZE_MINUTES, CSR_DATA_W'($urandom_range(59, 1)));
      write_csr(CSR_RING_TIMEOUT, 255);
      push_stop();
      push_set(0, 5, 30, 1'b1);
      push_tick(5, 30);
      repeat (257) push_tick(5, 31);
      run_random(100);
      wait_idle();

      steady = 1'b1;
      write_csr(CSR_SNOOZE_MINUTES, CSR_DATA_W'($urandom_range(59, 1)));
      write_csr(CSR_RING_TIMEOUT, CSR_DATA_W'($urandom_range(9, 2)));
      run_random(200);
      wait_idle();
      steady = 1'b0;

      write_csr(CSR_SNOOZE_MINUTES, CSR_DATA_W'($urandom_range(59, 1)));
      write_csr(CSR_RING_TIMEOUT, CSR_DATA_W'($urandom_range(9, 2)));
      run_random(100);
      wait_idle();
      run_random(100);
      wait_idle();

      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("alarm_slot_matcher_with_snooze_test passed");
      end else begin
         $display("alarm_slot_matcher_with_snooze_test failed");
      end
      $finish;
   end

endmodule

### alarm_slot_matcher_with_snooze.f
sv/alsm_pkg.sv
sv/alarm_slot_matcher_with_snooze.sv
test/alarm_slot_matcher_with_snooze_test.sv
